/* sv/ctlt_pkg.sv */
`timescale 1ns / 1ps

package ctlt_pkg;

	localparam int SLOTS_DEF = 5;
	localparam int ID_W      = 3;
	localparam int CNT_W     = 3;
	localparam int CAP_MAX   = 7;

	localparam logic OP_PROCESS = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [ID_W-1:0]  slot_id;
		logic             tip;
		logic             confidence;
		logic [15:0]      pos_x;
		logic [15:0]      pos_y;
		logic [7:0]       pressure;
		logic [15:0]      frame_stamp;
		logic [7:0]       btn_bits;
	} in_item_t;

	typedef struct packed {
		logic             finger_valid;
		logic [CNT_W-1:0] contact_index;
		logic [ID_W-1:0]  contact_id;
		logic             tip_out;
		logic             confidence_out;
		logic [15:0]      x_out;
		logic [15:0]      y_out;
		logic [7:0]       pressure_out;
		logic [CNT_W-1:0] record_total;
		logic [15:0]      stamp_out;
		logic             button;
	} out_item_t;

endpackage

/* sv/ctlt_tracker.sv */
`timescale 1ns / 1ps

module ctlt_tracker #(
	parameter int SLOTS = ctlt_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  ctlt_pkg::in_item_t   item,
	output ctlt_pkg::out_item_t  result
);
	import ctlt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CAP   = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;
	localparam logic [4:0]       SLOTS_V = 5'(SLOTS);
	localparam logic [CNT_W-1:0] CAP_V   = CNT_W'(CAP);

	logic [SLOTS-1:0] active_q;
	logic [15:0]      last_x_q    [SLOTS];
	logic [15:0]      last_y_q    [SLOTS];
	logic             last_conf_q [SLOTS];
	logic [CNT_W-1:0] count_q;

	logic [IDX_W-1:0] idx;
	logic             in_range;
	logic             was_active;
	logic [CNT_W-1:0] base_cnt;
	logic             emit;
	logic [CNT_W-1:0] next_cnt;
	logic             is_clear;

	assign is_clear   = (item.operation == OP_CLEAR);
	assign idx        = IDX_W'(item.slot_id);
	assign in_range   = ({2'b00, item.slot_id} < SLOTS_V);
	assign was_active = in_range && active_q[idx];
	assign base_cnt   = (item.slot_id == '0) ? '0 : count_q;
	assign emit       = in_range && (item.tip || was_active) && (base_cnt < CAP_V);

	always_comb begin
		if (!in_range) begin
			next_cnt = count_q;
		end else if (emit) begin
			next_cnt = base_cnt + CNT_W'(1);
		end else begin
			next_cnt = base_cnt;
		end
	end

	always_comb begin
		result = '0;
		if (!is_clear) begin
			result.record_total = next_cnt;
			result.stamp_out    = item.frame_stamp;
			result.button       = |item.btn_bits;
			if (emit) begin
				result.finger_valid  = 1'b1;
				result.contact_index = base_cnt;
				result.contact_id    = item.slot_id;
				if (item.tip) begin
					result.tip_out        = 1'b1;
					result.confidence_out = item.confidence;
					result.x_out          = item.pos_x;
					result.y_out          = item.pos_y;
					result.pressure_out   = item.pressure;
				end else begin
					result.confidence_out = last_conf_q[idx];
					result.x_out          = last_x_q[idx];
					result.y_out          = last_y_q[idx];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			count_q  <= '0;
		end else if (fire) begin
			if (is_clear) begin
				active_q <= '0;
				count_q  <= '0;
			end else if (in_range) begin
				active_q[idx] <= item.tip;
				count_q       <= next_cnt;
			end
		end
	end

	// position memory is only read behind a set active bit
	always_ff @(posedge clk) begin
		if (fire && !is_clear && in_range && item.tip) begin
			last_x_q[idx]    <= item.pos_x;
			last_y_q[idx]    <= item.pos_y;
			last_conf_q[idx] <= item.confidence;
		end
	end

endmodule

/* sv/touch_contact_lift_tracker_top.sv */
`timescale 1ns / 1ps

// Multitouch contact report builder. One slot per transfer, one result per
// transfer; a new slot is taken every cycle while item_stall is low. Input
// register, then slot lookup and count update feeding the result register.
// Slot state lives in flip-flops, so slot N of the next transfer sees the
// update from the transfer just before it. A clear operation zeroes tracking.
module touch_contact_lift_tracker_top #(
	parameter int SLOTS = ctlt_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  ctlt_pkg::in_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output ctlt_pkg::out_item_t  result
);
	import ctlt_pkg::*;

	localparam int CAP = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;
	localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	out_item_t next_result;
	logic      adv_s2;

	assign adv_s2     = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	ctlt_tracker #(
		.SLOTS(SLOTS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s2),
		.item   (item_s1),
		.result (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= next_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_index_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.finger_valid
			|-> result_s2.record_total == result_s2.contact_index + CNT_W'(1))
		else $error("record index does not match running count");

	a_no_record_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.finger_valid
			|-> result_s2.tip_out == 1'b0 && result_s2.pressure_out == '0
			&& result_s2.x_out == '0 && result_s2.y_out == '0)
		else $error("contact fields set without a record");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.record_total <= CAP_V)
		else $error("contact count above cap");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("input stalled with room in the pipeline");

endmodule

/* dv/contact_report_checker.sv */
`timescale 1ns / 1ps

module contact_report_checker #(
	parameter int SLOTS = ctlt_pkg::SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_stall,
	input  ctlt_pkg::in_item_t  item,
	input  logic                result_valid,
	input  logic                result_stall,
	input  ctlt_pkg::out_item_t result,
	output int                  fail_count,
	output int                  pending
);
	import ctlt_pkg::*;

	localparam int REPORT_CAP = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;

	logic             slot_active [SLOTS];
	logic [15:0]      slot_x      [SLOTS];
	logic [15:0]      slot_y      [SLOTS];
	logic             slot_conf   [SLOTS];
	logic [CNT_W-1:0] report_count;
	out_item_t        report_q [$];

	function automatic void clear_tracking();
		for (int s = 0; s < SLOTS; s++) begin
			slot_active[s] = 1'b0;
			slot_x[s]      = '0;
			slot_y[s]      = '0;
			slot_conf[s]   = 1'b0;
		end
		report_count = '0;
	endfunction

	function automatic out_item_t predict_report(input in_item_t it);
		out_item_t r;
		out_item_t rec;
		logic      emit;
		int        s;
		r    = '0;
		rec  = '0;
		emit = 1'b0;
		s    = int'(it.slot_id);
		if (it.operation == OP_CLEAR) begin
			clear_tracking();
			return r;
		end
		if (s < SLOTS) begin
			if (s == 0)
				report_count = '0;
			if (it.tip) begin
				slot_active[s]     = 1'b1;
				slot_x[s]          = it.pos_x;
				slot_y[s]          = it.pos_y;
				slot_conf[s]       = it.confidence;
				emit               = 1'b1;
				rec.tip_out        = 1'b1;
				rec.confidence_out = it.confidence;
				rec.x_out          = it.pos_x;
				rec.y_out          = it.pos_y;
				rec.pressure_out   = it.pressure;
			end else if (slot_active[s]) begin
				// lift: replay last known contact once
				slot_active[s]     = 1'b0;
				emit               = 1'b1;
				rec.confidence_out = slot_conf[s];
				rec.x_out          = slot_x[s];
				rec.y_out          = slot_y[s];
			end
			if (emit && report_count >= REPORT_CAP)
				emit = 1'b0;
			if (emit) begin
				r                = rec;
				r.finger_valid   = 1'b1;
				r.contact_index  = report_count;
				r.contact_id     = it.slot_id;
				report_count     = report_count + 1'b1;
			end
		end
		r.record_total = report_count;
		r.stamp_out    = it.frame_stamp;
		r.button       = |it.btn_bits;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch %s: expected %0h actual %0h at %0t",
					fname, exp_v, act_v, $time);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			clear_tracking();
			report_q.delete();
			pending = 0;
		end else begin
			if (item_valid && !item_stall)
				report_q.push_back(predict_report(item));
			if (result_valid && !result_stall) begin
				if (report_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer %p at %0t", result, $time);
				end else begin
					exp_r = report_q.pop_front();
					check_field("finger_valid", exp_r.finger_valid, result.finger_valid);
					check_field("contact_index", exp_r.contact_index, result.contact_index);
					check_field("contact_id", exp_r.contact_id, result.contact_id);
					check_field("tip_out", exp_r.tip_out, result.tip_out);
					check_field("confidence_out", exp_r.confidence_out,
						result.confidence_out);
					check_field("x_out", exp_r.x_out, result.x_out);
					check_field("y_out", exp_r.y_out, result.y_out);
					check_field("pressure_out", exp_r.pressure_out, result.pressure_out);
					check_field("record_total", exp_r.record_total, result.record_total);
					check_field("stamp_out", exp_r.stamp_out, result.stamp_out);
					check_field("button", exp_r.button, result.button);
				end
			end
			pending = report_q.size();
		end
	end

endmodule

/* dv/touch_contact_lift_tracker_top_tb.sv */
`timescale 1ns / 1ps

module touch_contact_lift_tracker_top_tb;
	import ctlt_pkg::*;

	localparam int RUN_ITEMS   = 1800;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_AT     = 600;
	localparam int SLOT_MAX    = (1 << ID_W) - 1;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_item_t  item;
	logic      result_valid;
	logic      result_stall;
	out_item_t result;

	int          fail_count;
	int          pending;
	int          items_sent;
	int          burst_left;
	int          cycle_count;
	logic        hold_go;
	logic [15:0] frame_scan;
	logic [7:0]  frame_buttons;

	touch_contact_lift_tracker_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	contact_report_checker #(
		.SLOTS (SLOTS_DEF)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("touch_contact_lift_tracker_top verification failed");
		$finish;
	end

	// receiver: segments of differing stall density, plus one long hold-off
	initial begin
		int   seg_left;
		int   mode;
		int   hold_left;
		logic hold_done;
		result_stall = 1'b0;
		seg_left     = 0;
		mode         = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		forever begin
			@(negedge clk);
			if (seg_left == 0) begin
				mode     = $urandom_range(0, 3);
				seg_left = $urandom_range(5, 60);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_stall = 1'b1;
			end else if (hold_go && !hold_done) begin
				hold_done    = 1'b1;
				hold_left    = 399;
				result_stall = 1'b1;
			end else begin
				case (mode)
					0: result_stall = 1'b0;
					1: result_stall = ($urandom_range(0, 9) < 3);
					2: result_stall = ($urandom_range(0, 9) < 7);
					default: result_stall = ~result_stall;
				endcase
			end
		end
	end

	function automatic in_item_t make_slot(input int slot, input logic touch);
		in_item_t it;
		it.operation   = OP_PROCESS;
		it.slot_id     = ID_W'(slot);
		it.tip         = touch;
		it.confidence  = 1'($urandom_range(0, 1));
		it.pos_x       = 16'($urandom);
		it.pos_y       = 16'($urandom);
		it.pressure    = 8'($urandom);
		it.frame_stamp = frame_scan;
		it.btn_bits    = frame_buttons;
		return it;
	endfunction

	task automatic new_frame();
		frame_scan    = 16'($urandom);
		frame_buttons = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
	endtask

	task automatic send_item(input in_item_t it);
		int gap;
		@(negedge clk);
		item_valid = 1'b1;
		item       = it;
		do begin
			@(posedge clk);
		end while (item_stall !== 1'b0);
		items_sent++;
		if (items_sent == HOLD_AT)
			hold_go = 1'b1;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	task automatic send_frame(input int nslots, input int touch_pct);
		for (int s = 0; s < nslots; s++)
			send_item(make_slot(s, $urandom_range(0, 99) < touch_pct));
	endtask

	initial begin
		in_item_t it;
		int       pick;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		hold_go       = 1'b0;
		items_sent    = 0;
		burst_left    = 0;
		frame_scan    = '0;
		frame_buttons = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// touch frame with field extremes, slot 2 idle
		new_frame();
		it = make_slot(0, 1'b1);
		it.confidence  = 1'b1;
		it.pos_x       = 16'hFFFF;
		it.pos_y       = 16'h0000;
		it.pressure    = 8'hFF;
		it.frame_stamp = 16'hFFFF;
		it.btn_bits    = 8'h00;
		send_item(it);
		it = make_slot(1, 1'b1);
		it.confidence  = 1'b0;
		it.pos_x       = 16'h0000;
		it.pos_y       = 16'hFFFF;
		it.pressure    = 8'h00;
		it.frame_stamp = 16'h0000;
		it.btn_bits    = 8'h80;
		send_item(it);
		send_item(make_slot(2, 1'b0));
		send_item(make_slot(3, 1'b1));
		send_item(make_slot(4, 1'b1));

		// all lifted: replayed lifts, slot 2 stays silent
		new_frame();
		send_frame(SLOTS_DEF, 0);

		// ignored slots beyond the array
		for (int s = SLOTS_DEF; s <= SLOT_MAX; s++)
			send_item(make_slot(s, 1'b1));

		// full report, then records past the cap without a restart
		new_frame();
		send_frame(SLOTS_DEF, 100);
		send_item(make_slot(1, 1'b1));
		send_item(make_slot(2, 1'b0));

		// clear with every field set, then a lift that must not report
		it = '1;
		it.operation = OP_CLEAR;
		send_item(it);
		send_item(make_slot(0, 1'b0));

		while (items_sent < RUN_ITEMS) begin
			pick = $urandom_range(0, 99);
			new_frame();
			if (pick < 78) begin
				send_frame(SLOTS_DEF, $urandom_range(10, 95));
			end else if (pick < 84) begin
				send_frame($urandom_range(1, SLOTS_DEF - 1), $urandom_range(10, 95));
			end else if (pick < 90) begin
				repeat ($urandom_range(3, 8))
					send_item(make_slot($urandom_range(0, SLOT_MAX),
						1'($urandom_range(0, 1))));
			end else if (pick < 94) begin
				send_item(make_slot($urandom_range(SLOTS_DEF, SLOT_MAX),
					1'($urandom_range(0, 1))));
			end else begin
				it = make_slot($urandom_range(0, SLOT_MAX), 1'($urandom_range(0, 1)));
				it.operation = OP_CLEAR;
				send_item(it);
			end
		end

		@(negedge clk);
		item_valid = 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("touch_contact_lift_tracker_top verification clean");
		else
			$display("touch_contact_lift_tracker_top verification failed");
		$finish;
	end

endmodule
